[src/lla_pkg.sv]
// Shared definitions for the life-like automaton grid.
// Holds operation codes, register indexes, reset values and the structs
// passed between the top level, the cell chain and the column update unit.
package lla_pkg;

  // Field widths fixed by the item format.
  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int SIZE_W  = 7;
  localparam int COUNT_W = 4;
  localparam int IDX_W   = 3;

  // Default grid dimensions.
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TOGGLE     = 3'd0;
  localparam logic [OP_W-1:0] OP_SET        = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_GRID = 3'd3;
  localparam logic [OP_W-1:0] OP_STEP       = 3'd4;
  localparam logic [OP_W-1:0] OP_READ       = 3'd5;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_ACTIVE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ACTIVE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_SURVIVE_MIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SURVIVE_MAX   = 3'd3;
  localparam logic [IDX_W-1:0] REG_BIRTH_COUNT   = 3'd4;

  // Register reset values.
  localparam logic [SIZE_W-1:0]  RST_ACTIVE_WIDTH  = 7'd64;
  localparam logic [SIZE_W-1:0]  RST_ACTIVE_HEIGHT = 7'd64;
  localparam logic [COUNT_W-1:0] RST_SURVIVE_MIN   = 4'd2;
  localparam logic [COUNT_W-1:0] RST_SURVIVE_MAX   = 4'd3;
  localparam logic [COUNT_W-1:0] RST_BIRTH_COUNT   = 4'd3;

  // Neighbor-count rule.
  typedef struct packed {
    logic [COUNT_W-1:0] survive_min;
    logic [COUNT_W-1:0] survive_max;
    logic [COUNT_W-1:0] birth_count;
  } rule_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic            clear;
    logic            shift;
    logic            edit_en;
    logic [OP_W-1:0] edit_op;
  } cell_ctrl_t;

endpackage

[src/lla_cell.sv]
// One cell of the column chain: holds one grid column.
// Depends on lla_pkg for the control struct and the operation codes.
module lla_cell import lla_pkg::*; #(
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctrl_t            ctrl,
  input  logic                  hit,
  input  logic [MAX_HEIGHT-1:0] row_hot,
  input  logic [MAX_HEIGHT-1:0] shift_in,
  output logic [MAX_HEIGHT-1:0] col,
  output logic                  rd_bit
);

  logic [MAX_HEIGHT-1:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      priority if (ctrl.clear) begin
        col_r <= '0;
      end else if (ctrl.shift) begin
        col_r <= shift_in;
      end else if (ctrl.edit_en && hit) begin
        unique case (ctrl.edit_op)
          OP_TOGGLE: col_r <= col_r ^ row_hot;
          OP_SET:    col_r <= col_r | row_hot;
          OP_CLEAR:  col_r <= col_r & ~row_hot;
          default:   col_r <= col_r;
        endcase
      end
    end
  end

  assign col    = col_r;
  assign rd_bit = hit & (|(col_r & row_hot));

endmodule

[src/lla_col_update.sv]
// Column update unit at the head of the cell chain.
// Counts the Moore neighbors of every row of one column and applies the rule.
// Depends on lla_pkg for the rule struct.
module lla_col_update import lla_pkg::*; #(
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
  input  logic [MAX_HEIGHT-1:0] above,
  input  logic [MAX_HEIGHT-1:0] cur,
  input  logic [MAX_HEIGHT-1:0] below,
  input  logic                  col_active,
  input  logic [HW-1:0]         h_eff,
  input  rule_t                 rule,
  output logic [MAX_HEIGHT-1:0] new_col
);

  // Zero padding on both ends stands in for cells outside the grid.
  logic [MAX_HEIGHT+1:0] a_pad, c_pad, b_pad;

  assign a_pad = {1'b0, above, 1'b0};
  assign c_pad = {1'b0, cur, 1'b0};
  assign b_pad = {1'b0, below, 1'b0};

  for (genvar y = 0; y < MAX_HEIGHT; y++) begin : g_row
    logic [COUNT_W-1:0] count;
    logic               alive;
    logic               next_bit;

    assign count = COUNT_W'(a_pad[y]) + COUNT_W'(a_pad[y+1]) + COUNT_W'(a_pad[y+2])
                 + COUNT_W'(c_pad[y]) + COUNT_W'(c_pad[y+2])
                 + COUNT_W'(b_pad[y]) + COUNT_W'(b_pad[y+1]) + COUNT_W'(b_pad[y+2]);
    assign alive = cur[y];
    assign next_bit = (alive && count >= rule.survive_min && count <= rule.survive_max)
                   || (count == rule.birth_count);
    assign new_col[y] = (col_active && (HW'(y) < h_eff)) ? next_bit : cur[y];
  end

endmodule

[src/life_like_automaton_grid.sv]
// Life-like automaton grid: edits, reads and generation steps on a bit grid.
// Sequence: toggle, set, clear and read pass the edit, read and done states; clear grid
// and the unused codes pass edit and done; a generation step passes edit, sweep and done.
// Throughput: one item at a time, the next taken the cycle after the result is loaded;
// a step takes one full rotation of the column chain.
// Reset: synchronous rst_n clears every cell at once and loads the register defaults.
module life_like_automaton_grid import lla_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [5:0] x_pos, [11:6] y_pos, [15:12] zero
  input  logic [OP_W-1:0]   in_tuser,   // [2:0] operation
  // Result channel.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [0] cell_value, [1] position_rejected, [7:2] zero
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = (WW > SIZE_W) ? ((WW > HW) ? WW : HW)
                                      : ((SIZE_W > HW) ? SIZE_W : HW);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EDIT  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Configuration registers. The port never stalls.
  logic [SIZE_W-1:0] active_width_r, active_height_r;
  rule_t             rule_r;
  logic              cfg_fire, size_write;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign size_write = cfg_fire &&
                      (cfg_index == REG_ACTIVE_WIDTH || cfg_index == REG_ACTIVE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r     <= RST_ACTIVE_WIDTH;
      active_height_r    <= RST_ACTIVE_HEIGHT;
      rule_r.survive_min <= RST_SURVIVE_MIN;
      rule_r.survive_max <= RST_SURVIVE_MAX;
      rule_r.birth_count <= RST_BIRTH_COUNT;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_ACTIVE_WIDTH:  active_width_r     <= cfg_data;
        REG_ACTIVE_HEIGHT: active_height_r    <= cfg_data;
        REG_SURVIVE_MIN:   rule_r.survive_min <= cfg_data[COUNT_W-1:0];
        REG_SURVIVE_MAX:   rule_r.survive_max <= cfg_data[COUNT_W-1:0];
        REG_BIRTH_COUNT:   rule_r.birth_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: a register value above the grid maximum acts as the maximum.
  logic [CMPW-1:0] w_wide, h_wide;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;

  assign w_wide = (CMPW'(active_width_r) > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH)
                                                             : CMPW'(active_width_r);
  assign h_wide = (CMPW'(active_height_r) > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT)
                                                               : CMPW'(active_height_r);
  assign w_eff  = WW'(w_wide);
  assign h_eff  = HW'(h_wide);

  // Input transaction and the position tests, captured at accept.
  logic [POS_W-1:0] x_in, y_in;
  logic             in_fire, inside_in, valid_in;

  assign x_in      = in_tdata[POS_W-1:0];
  assign y_in      = in_tdata[2*POS_W-1:POS_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign inside_in = (CMPW'(x_in) < w_wide) && (CMPW'(y_in) < h_wide);
  assign valid_in  = inside_in && (x_in != '0) && (y_in != '0);

  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] x_r, y_r;
  logic             inside_r, valid_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_tuser;
      x_r      <= x_in;
      y_r      <= y_in;
      inside_r <= inside_in;
      valid_r  <= valid_in;
    end
  end

  logic is_edit, is_cell_op;

  assign is_edit    = (op_r == OP_TOGGLE) || (op_r == OP_SET) || (op_r == OP_CLEAR);
  assign is_cell_op = is_edit || (op_r == OP_READ);

  // Column select and row select, one-hot over the chain and over a column.
  logic [MAX_WIDTH-1:0]  col_hit;
  logic [MAX_HEIGHT-1:0] row_hot;

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col_hit
    assign col_hit[i] = (32'(x_r) == i);
  end
  for (genvar j = 0; j < MAX_HEIGHT; j++) begin : g_row_hot
    assign row_hot[j] = (32'(y_r) == j);
  end

  // Sweep counter: the grid column now sitting at the head of the chain.
  logic [XW-1:0] sweep_cnt_r;
  logic          sweep_last, col_active, below_valid;

  assign sweep_last  = (sweep_cnt_r == XW'(MAX_WIDTH - 1));
  assign col_active  = (WW'(sweep_cnt_r) < w_eff);
  assign below_valid = ((WW'(sweep_cnt_r) + WW'(1)) < w_eff);

  // The chain. Cell 0 holds the column under update; every sweep cycle each cell
  // takes its neighbor's column and the last cell takes the freshly updated one,
  // so after a full sweep every column is back in its own cell.
  cell_ctrl_t            ctrl;
  logic [MAX_HEIGHT-1:0] cols    [MAX_WIDTH];
  logic [MAX_WIDTH-1:0]  rd_hits;
  logic [MAX_HEIGHT-1:0] new_col, snap_above_r, below_col;

  assign ctrl.clear   = size_write || (state_r == ST_EDIT && op_r == OP_CLEAR_GRID);
  assign ctrl.shift   = (state_r == ST_SWEEP);
  assign ctrl.edit_en = (state_r == ST_EDIT) && is_edit && valid_r;
  assign ctrl.edit_op = op_r;

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    logic [MAX_HEIGHT-1:0] shift_src;
    if (i == MAX_WIDTH - 1) begin : g_tail
      assign shift_src = new_col;
    end else begin : g_link
      assign shift_src = cols[i+1];
    end
    lla_cell #(
      .MAX_HEIGHT(MAX_HEIGHT)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .hit     (col_hit[i]),
      .row_hot (row_hot),
      .shift_in(shift_src),
      .col     (cols[i]),
      .rd_bit  (rd_hits[i])
    );
  end

  // The neighbor column beyond the active width is dead; past the last column
  // the chain already holds updated values, so it is masked off.
  assign below_col = below_valid ? cols[1] : '0;

  lla_col_update #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .HW        (HW)
  ) u_col_update (
    .above     (snap_above_r),
    .cur       (cols[0]),
    .below     (below_col),
    .col_active(col_active),
    .h_eff     (h_eff),
    .rule      (rule_r),
    .new_col   (new_col)
  );

  // Snapshot of the previous column before its update, and the sweep count.
  always_ff @(posedge clk) begin
    if (state_r == ST_EDIT) begin
      snap_above_r <= '0;
      sweep_cnt_r  <= '0;
    end else if (state_r == ST_SWEEP) begin
      snap_above_r <= cols[0];
      sweep_cnt_r  <= sweep_cnt_r + XW'(1);
    end
  end

  // Read-back of the addressed cell after any edit has landed.
  logic rd_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      rd_r <= |rd_hits;
    end
  end

  // Output register: the next input transaction may be taken while it waits.
  logic out_valid_r, out_value_r, out_rej_r;
  logic out_load;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= is_cell_op && inside_r && rd_r;
      out_rej_r   <= is_edit && !valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_rej_r, out_value_r};

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EDIT;
      end
      ST_EDIT: begin
        if (is_cell_op) begin
          state_nxt = ST_READ;
        end else if (op_r == OP_STEP) begin
          state_nxt = ST_SWEEP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        if (sweep_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A step always enters the sweep with the counter at the first column.
  a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EDIT && op_r == OP_STEP) |=> (state_r == ST_SWEEP && sweep_cnt_r == '0))
    else $error("generation step did not start its sweep at column zero");

  // The sweep ends exactly after the last column has passed the head.
  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && sweep_last) |=> (state_r == ST_DONE))
    else $error("sweep did not finish after the last column");

  // Grid-wide operations never report a cell value or a rejection.
  a_grid_op_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (op_r == OP_CLEAR_GRID || op_r == OP_STEP))
      |=> (out_tdata[0] == 1'b0 && out_tdata[1] == 1'b0))
    else $error("grid-wide operation produced a nonzero result");

  // After a clear-grid operation no cell reads as live.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EDIT && op_r == OP_CLEAR_GRID) |=> (rd_hits == '0))
    else $error("grid not empty after clear");

endmodule
